@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared widths, operation codes and structures of the GF(2^m) unit.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int POLY_W     = MAX_DEGREE + 1;
  localparam int DEG_W      = $clog2(POLY_W);
  localparam int DATA_W     = 32;
  localparam int DATA_IDX_W = $clog2(DATA_W);
  localparam int KIND_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;

  localparam logic [POLY_W-1:0] RESET_POLY = POLY_W'(283);
  localparam logic [DEG_W-1:0]  RESET_DEG  = DEG_W'(8);

  typedef struct packed {
    logic [POLY_W-1:0] poly;
    logic [DEG_W-1:0]  deg;
    logic [DATA_W-1:0] mask;
    logic [POLY_W-1:0] top;
    logic              busy;
  } field_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              status;
    logic              less;
    logic              equal;
  } res_t;

endpackage

@@ rtl/bfa_if.sv @@
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channel interfaces for operations, results and configuration.
// ----------------------------------------------------------------------------
interface bfa_in_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  logic              status;
  logic              less;
  logic              equal;

  modport source (output valid, output result, output status, output less,
                  output equal, input ready);
  modport sink   (input valid, input result, input status, input less,
                  input equal, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POLY_W-1:0] field_poly;

  modport source (output valid, output field_poly, input ready);
  modport sink   (input valid, input field_poly, output ready);
endinterface

@@ rtl/bfa_field.sv @@
// ----------------------------------------------------------------------------
// bfa_field
// Field polynomial register with a serial scan for its degree.
// ----------------------------------------------------------------------------
module bfa_field import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [POLY_W-1:0] wr_data,
  output field_t            field
);

  logic [POLY_W-1:0] poly_r, poly_nxt;
  logic [DEG_W-1:0]  deg_r, deg_nxt;
  logic [DATA_W-1:0] mask_r, mask_nxt;
  logic [POLY_W-1:0] top_r, top_nxt;
  logic              busy_r, busy_nxt;
  logic [DEG_W-1:0]  pos_r, pos_nxt;
  logic [POLY_W-1:0] ones_sh;

  // The scan walks down from the highest coefficient, one bit per cycle.
  always_comb begin
    poly_nxt = poly_r;
    deg_nxt  = deg_r;
    mask_nxt = mask_r;
    top_nxt  = top_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    ones_sh  = {POLY_W{1'b1}} << pos_r;
    if (wr_en) begin
      poly_nxt = wr_data;
      pos_nxt  = DEG_W'(MAX_DEGREE);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (poly_r[pos_r] || (pos_r == '0)) begin
        deg_nxt  = pos_r;
        mask_nxt = ~ones_sh[DATA_W-1:0];
        top_nxt  = POLY_W'(1) << pos_r;
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= RESET_POLY;
      deg_r  <= RESET_DEG;
      mask_r <= DATA_W'((POLY_W'(1) << RESET_DEG) - POLY_W'(1));
      top_r  <= POLY_W'(1) << RESET_DEG;
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      poly_r <= poly_nxt;
      deg_r  <= deg_nxt;
      mask_r <= mask_nxt;
      top_r  <= top_nxt;
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign field.poly = poly_r;
  assign field.deg  = deg_r;
  assign field.mask = mask_r;
  assign field.top  = top_r;
  assign field.busy = busy_r;

endmodule

@@ rtl/bfa_core.sv @@
// ----------------------------------------------------------------------------
// bfa_core
// Bit-serial multiplier and Euclidean inverter with a small sequencer.
// ----------------------------------------------------------------------------
module bfa_core import bfa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  field_t field,
  input  logic   start,
  input  op_t    op,
  output logic   busy,
  output logic   res_valid,
  output res_t   res,
  input  logic   res_take
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] mb_r, mb_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DEG_W-1:0]  cnt_r, cnt_nxt;
  logic [POLY_W-1:0] r_r, r_nxt, nr_r, nr_nxt, t_r, t_nxt, nt_r, nt_nxt;
  logic [DEG_W-1:0]  dr_r, dr_nxt, dn_r, dn_nxt, p_r, p_nxt;
  res_t              res_r, res_nxt;

  logic [DATA_W-1:0] a_m, b_m;
  logic [DEG_W-1:0]  sh;
  logic [POLY_W-1:0] r_x, t_x;
  logic [DEG_W-1:0]  cnt_m1;
  logic [POLY_W-1:0] acc_sh, acc_red;

  assign a_m    = op.a & field.mask;
  assign b_m    = op.b & field.mask;
  assign sh     = p_r - dn_r;
  assign r_x    = r_r[p_r] ? (r_r ^ (nr_r << sh)) : r_r;
  assign t_x    = r_r[p_r] ? (t_r ^ (nt_r << sh)) : t_r;
  assign cnt_m1 = cnt_r - 1'b1;
  // Shift the product one place up and fold the overflow bit back in.
  assign acc_sh  = {acc_r, 1'b0};
  assign acc_red = (|(acc_sh & field.top)) ? (acc_sh ^ field.poly) : acc_sh;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    nr_nxt    = nr_r;
    t_nxt     = t_r;
    nt_nxt    = nt_r;
    dr_nxt    = dr_r;
    dn_nxt    = dn_r;
    p_nxt     = p_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = op.kind;
          a_nxt     = a_m;
          res_nxt   = '0;
          acc_nxt   = '0;
          cnt_nxt   = field.deg;
          r_nxt     = field.poly;
          t_nxt     = '0;
          nt_nxt    = POLY_W'(1);
          dr_nxt    = field.deg;
          p_nxt     = field.deg - 1'b1;
          state_nxt = S_FIN;
          unique case (op.kind)
            KIND_ADD: res_nxt.result = a_m ^ b_m;
            KIND_MUL: begin
              mb_nxt    = b_m;
              state_nxt = S_MUL;
            end
            KIND_DIV: begin
              if (b_m == '0) begin
                res_nxt.status = 1'b1;
              end else begin
                nr_nxt    = POLY_W'(b_m);
                state_nxt = S_SCAN;
              end
            end
            KIND_INV: begin
              if (a_m == '0) begin
                res_nxt.status = 1'b1;
              end else begin
                nr_nxt    = POLY_W'(a_m);
                state_nxt = S_SCAN;
              end
            end
            KIND_CMP: begin
              res_nxt.less  = a_m < b_m;
              res_nxt.equal = a_m == b_m;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Find the degree of the divisor; it is known to be nonzero here.
        if (nr_r[p_r]) begin
          dn_nxt    = p_r;
          p_nxt     = dr_r;
          state_nxt = S_DIV;
        end else begin
          p_nxt = p_r - 1'b1;
        end
      end
      S_DIV: begin
        if (p_r == dn_r) begin
          r_nxt  = nr_r;
          nr_nxt = r_x;
          t_nxt  = nt_r;
          nt_nxt = t_x;
          dr_nxt = dn_r;
          if (r_x == '0) begin
            if (kind_r == KIND_DIV) begin
              mb_nxt    = nt_r[DATA_W-1:0] & field.mask;
              state_nxt = S_MUL;
            end else begin
              res_nxt.result = nt_r[DATA_W-1:0] & field.mask;
              state_nxt      = S_FIN;
            end
          end else begin
            p_nxt     = dn_r - 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          r_nxt = r_x;
          t_nxt = t_x;
          p_nxt = p_r - 1'b1;
        end
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          res_nxt.result = acc_r & field.mask;
          state_nxt      = S_FIN;
        end else begin
          acc_nxt = acc_red[DATA_W-1:0] ^
                    (mb_r[cnt_m1[DATA_IDX_W-1:0]] ? a_r : '0);
          cnt_nxt = cnt_m1;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    a_r    <= a_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    r_r    <= r_nxt;
    nr_r   <= nr_nxt;
    t_r    <= t_nxt;
    nt_r   <= nt_nxt;
    dr_r   <= dr_nxt;
    dn_r   <= dn_nxt;
    p_r    <= p_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign res_valid = state_r == S_FIN;
  assign res       = res_r;

endmodule

@@ rtl/binary_field_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit
// GF(2^m) polynomial basis arithmetic: add, multiply, divide, inverse, compare.
// ----------------------------------------------------------------------------
// Operations arrive on in_ch and results leave on out_ch; a transfer happens
// when valid and ready are both high. cfg_ch writes the field polynomial,
// and m is the position of its top set bit.
// The core works on one operation at a time. Add and compare need no loop,
// and multiply runs the bit-serial shift-and-reduce loop. Inverse runs the
// Euclidean sequencer at one quotient bit or one degree-search bit per cycle,
// and divide adds a multiply after it. A finished result sits in the output
// register, so the next operation is accepted while the receiver stalls; the
// core then waits with its own result until the register is free.
// While a polynomial write is offered no operation is accepted, and after the
// write the degree is found by a serial scan from the top bit. Reset loads
// x^8+x^4+x^3+x+1.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit import bfa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  bfa_in_if.sink     in_ch,
  bfa_out_if.source  out_ch,
  bfa_cfg_if.sink    cfg_ch
);

  field_t field;
  op_t    op;
  res_t   core_res;
  logic   core_busy, core_res_valid, res_take;
  logic   in_fire, cfg_fire;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_r;

  assign in_ch.ready  = !core_busy && !field.busy && !cfg_ch.valid;
  assign cfg_ch.ready = !core_busy && !field.busy && !out_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign op.kind = in_ch.kind;
  assign op.a    = in_ch.operand_a;
  assign op.b    = in_ch.operand_b;

  bfa_field u_field (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_fire),
    .wr_data (cfg_ch.field_poly),
    .field   (field)
  );

  bfa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .field     (field),
    .start     (in_fire),
    .op        (op),
    .busy      (core_busy),
    .res_valid (core_res_valid),
    .res       (core_res),
    .res_take  (res_take)
  );

  assign res_take = core_res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_r.result;
  assign out_ch.status = out_r.status;
  assign out_ch.less   = out_r.less;
  assign out_ch.equal  = out_r.equal;

`ifndef NO_ASSERTIONS
  a_no_cfg_with_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && cfg_fire))
    else $error("operation and configuration transfer in the same cycle");

  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("operation accepted while the core was still busy");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |-> (out_r.result == '0))
    else $error("division by zero with a nonzero result");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.less && out_r.equal))
    else $error("less and equal both set");

  a_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.result & ~field.mask) == '0))
    else $error("result wider than the field");
`endif

endmodule

@@ tb/binary_field_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit_tb
// Self-checking bench for the GF(2^m) arithmetic unit. Operations are driven
// through the input channel with random gaps, and every result is compared
// field by field with a bit-exact software predictor of the field arithmetic.
// The field polynomial is rewritten between phases: the reset field,
// degenerate and tiny fields, reducible fields, the widest and random fields.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit_tb import bfa_pkg::*; ();

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 250;
  localparam int MAX_REPORTS  = 20;
  localparam logic [KIND_W-1:0] KIND_TOP = '1;

  logic clk;
  logic rst_n;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();
  bfa_cfg_if cfg_ch ();

  binary_field_arithmetic_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  res_t              pending_results[$];
  logic [POLY_W-1:0] field_poly_model;
  int unsigned       n_errors;
  int unsigned       n_items;
  int unsigned       n_results;
  int unsigned       n_polys;
  int unsigned       hold_off_cycles;
  int unsigned       tx_calm;
  int unsigned       rx_calm;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Field arithmetic predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned poly_degree(logic [63:0] p);
    int unsigned d;
    d = 0;
    for (int i = 1; i < 64; i++) if (p[i]) d = i;
    return d;
  endfunction

  function automatic logic [63:0] carryless_mul(logic [63:0] x, logic [63:0] y);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i++) if (y[i]) acc ^= x << i;
    return acc;
  endfunction

  function automatic logic [63:0] reduce_mod(logic [63:0] x, logic [63:0] poly,
                                             int unsigned m);
    for (int i = 63; i >= int'(m); i--) if (x[i]) x ^= poly << (i - int'(m));
    return x;
  endfunction

  // Extended Euclid on (poly, a); for a reducible polynomial this yields the
  // cofactor of the gcd rather than a true inverse.
  function automatic logic [63:0] euclid_inverse(logic [63:0] a, logic [63:0] poly);
    logic [63:0] r, nr, t, nt, tmp;
    int unsigned dn, s;
    r  = poly;
    nr = a;
    t  = '0;
    nt = 64'd1;
    while (nr != 0) begin
      dn = poly_degree(nr);
      while (r != 0 && poly_degree(r) >= dn) begin
        s = poly_degree(r) - dn;
        r ^= nr << s;
        t ^= nt << s;
      end
      tmp = r;  r = nr;  nr = tmp;
      tmp = t;  t = nt;  nt = tmp;
    end
    return t;
  endfunction

  function automatic res_t gf_compute(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] a,
                                      logic [DATA_W-1:0] b);
    res_t        e;
    logic [63:0] poly, mask, am, bm, v;
    int unsigned m;
    poly = 64'(field_poly_model);
    m    = (poly >= 2) ? poly_degree(poly) : 0;
    mask = (m == 0) ? '0 : ((64'd1 << m) - 1);
    am   = 64'(a) & mask;
    bm   = 64'(b) & mask;
    v    = '0;
    e    = '0;
    case (kind)
      KIND_ADD: v = am ^ bm;
      KIND_MUL: if (m != 0) v = reduce_mod(carryless_mul(am, bm), poly, m);
      KIND_DIV: begin
        if (bm == 0) e.status = 1'b1;
        else v = reduce_mod(carryless_mul(am, euclid_inverse(bm, poly) & mask), poly, m);
      end
      KIND_INV: begin
        if (am == 0) e.status = 1'b1;
        else v = euclid_inverse(am, poly);
      end
      KIND_CMP: begin
        e.less  = (am < bm);
        e.equal = (am == bm);
      end
      default: ;
    endcase
    e.result = DATA_W'(v & mask);
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly no gap or a short one, now and then a long one, and occasionally a
  // run of back-to-back cycles.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return DATA_W'(1);
      2:       return '1;
      3:       return DATA_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind();
    if ($urandom_range(0, 99) < 6) return KIND_W'($urandom_range(KIND_CMP + 1, KIND_TOP));
    return KIND_W'($urandom_range(KIND_ADD, KIND_CMP));
  endfunction

  function automatic logic [POLY_W-1:0] rand_poly();
    int unsigned d;
    logic [63:0] p;
    if ($urandom_range(0, 1) == 0) return {1'($urandom_range(0, 1)), 32'($urandom())};
    d = $urandom_range(2, MAX_DEGREE);
    p = {32'($urandom()), 32'($urandom())};
    p = (p & ((64'd1 << d) - 1)) | (64'd1 << d);
    return POLY_W'(p);
  endfunction

  // --------------------------------------------------------------------------
  // Channel tasks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("MISMATCH %s at %0t ns: got %h, expected %h", what, $time, got, want);
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b, input bit gapless = 1'b0);
    int unsigned g;
    g = gapless ? 0 : pick_gap(tx_calm);
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(gf_compute(kind, a, b));
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_field_poly(input logic [POLY_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.field_poly <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    field_poly_model = value;
    n_polys++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: checks each transfer and then decides ready for the next
  // cycle, honouring any long hold-off requested by a test.
  initial begin
    res_t e;
    int unsigned rx_pause;
    rx_pause = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_ch.result), '0);
        end else begin
          e = pending_results.pop_front();
          if (out_ch.result !== e.result)
            report_mismatch("result", 64'(out_ch.result), 64'(e.result));
          if (out_ch.status !== e.status)
            report_mismatch("status", 64'(out_ch.status), 64'(e.status));
          if (out_ch.less !== e.less)
            report_mismatch("less", 64'(out_ch.less), 64'(e.less));
          if (out_ch.equal !== e.equal)
            report_mismatch("equal", 64'(out_ch.equal), 64'(e.equal));
        end
        rx_pause = pick_gap(rx_calm);
      end
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (rx_pause > 0) begin
        out_ch.ready <= 1'b0;
        rx_pause--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset field x^8+x^4+x^3+x+1: operand extremes, masking, every operation,
  // both division-by-zero cases and the unused operation codes.
  task automatic test_reset_field();
    send_op(KIND_ADD, '0, '0);
    send_op(KIND_ADD, '1, '1);
    send_op(KIND_ADD, 32'h53, 32'hCA);
    send_op(KIND_MUL, 32'h53, 32'hCA);
    send_op(KIND_MUL, '1, '1);
    send_op(KIND_MUL, '0, 32'h80);
    send_op(KIND_MUL, 32'h80, 32'h80);
    send_op(KIND_DIV, 32'h01, 32'h53);
    send_op(KIND_DIV, 32'h57, '0);
    send_op(KIND_DIV, '1, 32'h100);
    send_op(KIND_DIV, '0, 32'h03);
    send_op(KIND_INV, 32'h53, '1);
    send_op(KIND_INV, 32'h01, '0);
    send_op(KIND_INV, '0, '1);
    send_op(KIND_INV, 32'hFFFF_FF00, '0);
    send_op(KIND_INV, 32'hFF, 32'h1234_5678);
    send_op(KIND_CMP, 32'h5, 32'h5);
    send_op(KIND_CMP, 32'h3, 32'h9);
    send_op(KIND_CMP, 32'h9, 32'h3);
    send_op(KIND_CMP, 32'h105, 32'h5);
    send_op(KIND_CMP, '1, '0);
    for (int k = KIND_CMP + 1; k <= KIND_TOP; k++) send_op(KIND_W'(k), '1, '1);
  endtask

  // Polynomials 0 and 1 leave no field bits; x and x+1 leave one.
  task automatic test_tiny_fields();
    logic [POLY_W-1:0] polys[4];
    polys = '{POLY_W'(0), POLY_W'(1), POLY_W'(2), POLY_W'(3)};
    foreach (polys[p]) begin
      write_field_poly(polys[p]);
      for (int k = KIND_ADD; k <= KIND_CMP; k++) send_op(KIND_W'(k), '1, '1);
      send_op(KIND_DIV, '1, '0);
      send_op(KIND_CMP, '0, '1);
    end
  endtask

  // All-ones register value and x^32: both reducible, so the inverse gives
  // the Euclidean cofactor.
  task automatic test_reducible_fields();
    write_field_poly('1);
    send_op(KIND_INV, '1, '0);
    send_op(KIND_MUL, '1, '1);
    repeat (12) send_op(KIND_INV + KIND_W'($urandom_range(0, 1)), $urandom(), $urandom());
    write_field_poly(POLY_W'(1) << MAX_DEGREE);
    send_op(KIND_INV, 32'h8000_0000, '0);
    repeat (10) send_op(rand_kind(), rand_operand(), rand_operand());
  endtask

  // The receiver holds off long enough for the unit to fill and stall input.
  task automatic test_output_stall();
    write_field_poly(POLY_W'(33'h1_0000_008D));
    hold_off_cycles = STALL_CYCLES;
    repeat (16) send_op(rand_kind(), rand_operand(), rand_operand(), 1'b1);
  endtask

  task automatic test_random_fields();
    logic [POLY_W-1:0] known[7];
    known = '{POLY_W'(33'h7), POLY_W'(33'hB), POLY_W'(33'h13), POLY_W'(33'h11B),
              POLY_W'(33'h1100B), POLY_W'(33'h1_0000_008D), POLY_W'(33'h25)};
    for (int phase = 0; phase < 11; phase++) begin
      write_field_poly((phase < 7) ? known[phase] : rand_poly());
      repeat (50) send_op(rand_kind(), rand_operand(), rand_operand());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_ADD;
    in_ch.operand_a   = '0;
    in_ch.operand_b   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.field_poly = '0;
    out_ch.ready      = 1'b0;
    field_poly_model  = RESET_POLY;
    n_errors          = 0;
    n_items           = 0;
    n_results         = 0;
    n_polys           = 0;
    hold_off_cycles   = 0;
    tx_calm           = 0;
    rx_calm           = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_field();
    test_tiny_fields();
    test_reducible_fields();
    test_output_stall();
    test_random_fields();
    write_field_poly(RESET_POLY);
    send_op(KIND_MUL, 32'h53, 32'hCA);

    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", '0, 64'(pending_results.size()));

    $display("Summary: %0d operations over %0d polynomial writes, %0d results checked,",
             n_items, n_polys, n_results);
    $display("Summary: degrees 0 to %0d, reducible fields and a %0d-cycle output stall.",
             MAX_DEGREE, STALL_CYCLES);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles with %0d results pending", LIMIT_CYCLES,
             pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
